// ===== sv/fcrn_pkg.sv =====
// Shared constants, types and helper functions of the friction cone residual block.
package fcrn_pkg;

   localparam int FCRN_FRAC_BITS = 16;
   localparam int MU_FRAC        = 16;
   localparam logic [31:0] TOL_RESET = 32'd65;

   localparam int REQ_TDATA_W = 312;
   localparam int RSP_TDATA_W = 32;

   localparam int ITER_CNT_W    = 6;
   localparam int ITER_OPND_W   = 70;
   localparam int ITER_DIVSR_W  = 41;
   localparam int ITER_ROOT_W   = 38;
   localparam int ITER_REM_W    = 42;

   localparam logic [ITER_CNT_W-1:0] SQRT_STEPS = 6'd32;
   localparam logic [ITER_CNT_W-1:0] CONE_STEPS = 6'd38;
   localparam logic [ITER_CNT_W-1:0] TAN_STEPS  = 6'd32;

   typedef struct packed {
      logic                  start;
      logic                  is_sqrt;
      logic [ITER_CNT_W-1:0] steps;
   } fcrn_iter_cmd_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? (32'd0 - v) : v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
      if (!x[39] && (x[38:31] != 8'h00)) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (x[39] && (x[38:31] != 8'hFF)) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add64 = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endfunction

endpackage

// ===== sv/friction_cone_residual_norm.sv =====
// Top level: Coulomb friction natural-map residual norm over a stream of contacts.
//
//  Channel | Direction | Handshake          | Words
//  req_    | in        | tvalid/tready      | one contact per word, tlast ends a problem
//  rsp_    | out       | tvalid/tready      | one relative error per problem
//  csr_    | in        | wr_en, no back-pressure | tolerance, unsigned Q16.16
//
// A contact is taken only while the sequencer is idle. Each contact needs two square roots
// when the cone leaves the vector unchanged or zeroes it, and three divisions more when a
// true projection is needed; the last contact of a problem adds two square roots, the final
// division and the hand-over to the result register.
// The shared divide/square-root unit does all of these, and it resolves one bit a cycle.
// Reset is synchronous and clears both sums, the sequencer and the result valid flag.
// A finished result waits in its register; the next contact is taken meanwhile, and only a
// second result still unclaimed holds the sequencer in its emit state.
module friction_cone_residual_norm #(
   parameter int FRAC_BITS = fcrn_pkg::FCRN_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // From bit 0: reaction_n[31:0], reaction_t1, reaction_t2, vel_n, vel_t1, vel_t2 (32 each),
   // friction_coef (20), offset_n, offset_t1, offset_t2 (32 each), four zero bits.
   input  logic [fcrn_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,   // last_contact
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fcrn_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // error_value[31:0]
   output logic                                rsp_tuser,   // over_tolerance
   input  logic                                csr_wr_en,
   input  logic [31:0]                         csr_wr_data  // tolerance
);
   import fcrn_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE, ST_Q0, ST_Q1, ST_Q2, ST_U1, ST_U2, ST_SQU, ST_WSQU, ST_MNU, ST_VEC,
      ST_V1, ST_V2, ST_SQV, ST_WSQV, ST_MN, ST_MP, ST_MU2, ST_CHK, ST_WDIV, ST_S,
      ST_SCAP, ST_T1, ST_DT1, ST_WT1, ST_T2, ST_DT2, ST_WT2, ST_DIFF, ST_D0, ST_D1,
      ST_D2, ST_ACC, ST_LSQ1, ST_WLSQ1, ST_LSQ2, ST_WLSQ2, ST_FDIV, ST_WFDIV, ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]              tolerance_ff;
   logic                     rsp_tvalid_ff;
   logic [31:0]              rsp_tdata_ff;
   logic                     rsp_tuser_ff;

   // Captured contact
   logic signed [31:0]       r0_ff, r1_ff, r2_ff, u0_ff, u1_ff, u2_ff;
   logic signed [31:0]       q0_ff, q1_ff, q2_ff;
   logic [19:0]              mu_ff;
   logic                     last_ff;

   // Working values
   logic [69:0]              mul_ff;
   logic [63:0]              sumq_ff, x_ff;
   logic [31:0]              nut_ff, n_ff, s_ff, e_ff, err_ff;
   logic signed [31:0]       v0_ff, v1_ff, v2_ff, p1_ff, p2_ff, d0_ff, d1_ff, d2_ff;
   logic signed [38:0]       p0_ff;
   logic [51:0]              mn_ff, mup_ff;
   logic [63:0]              residual_sum_ff, offset_sum_ff;

   // Shared multiplier operands
   logic [37:0]              mul_a;
   logic [31:0]              mul_b;

   // Shared iterative unit
   fcrn_iter_cmd_type        iter_cmd;
   logic [ITER_OPND_W-1:0]   iter_opnd;
   logic [ITER_DIVSR_W-1:0]  iter_divsr;
   logic                     iter_done;
   logic [ITER_ROOT_W-1:0]   iter_result;

   logic [52:0]              mnu_round;
   logic [35:0]              mnu;
   logic signed [54:0]       a_val;
   logic                     zero_proj, keep_proj;
   logic [58:0]              s_round;
   logic [42:0]              s_raw;
   logic [63:0]              acc;
   logic                     rsp_free;

   fcrn_iter_unit u_iter (
      .clock   (clock),
      .reset   (reset),
      .cmd     (iter_cmd),
      .operand (iter_opnd),
      .divisor (iter_divsr),
      .done    (iter_done),
      .result  (iter_result)
   );

   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   // Datapath terms that are read in a single sequencer step.
   always_comb begin
      mnu_round = {1'b0, mul_ff[51:0]} + 53'(1 << (MU_FRAC - 1));
      mnu       = mnu_round[MU_FRAC +: 36];
      // a = mu*|v_t| + v_n, both with 32 fraction bits
      a_val     = $signed({3'b000, mn_ff}) + (55'(v0_ff) <<< MU_FRAC);
      zero_proj = a_val[54] || (a_val == 55'sd0);
      keep_proj = v0_ff[31] ? ((n_ff == 32'd0) && (mup_ff == 52'd0))
                            : (52'({n_ff, 16'h0000}) <= mup_ff);
      s_round   = {1'b0, mul_ff[57:0]} + 59'(1 << (MU_FRAC - 1));
      s_raw     = s_round[MU_FRAC +: 43];
      acc       = x_ff + mul_ff[63:0];
   end

   // Multiplier operand selection: the product is registered and used in the next step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_Q0:   begin mul_a = 38'(mag32(q0_ff)); mul_b = mag32(q0_ff); end
         ST_Q1:   begin mul_a = 38'(mag32(q1_ff)); mul_b = mag32(q1_ff); end
         ST_Q2:   begin mul_a = 38'(mag32(q2_ff)); mul_b = mag32(q2_ff); end
         ST_U1:   begin mul_a = 38'(mag32(u1_ff)); mul_b = mag32(u1_ff); end
         ST_U2:   begin mul_a = 38'(mag32(u2_ff)); mul_b = mag32(u2_ff); end
         ST_MNU:  begin mul_a = 38'(mu_ff); mul_b = nut_ff; end
         ST_V1:   begin mul_a = 38'(mag32(v1_ff)); mul_b = mag32(v1_ff); end
         ST_V2:   begin mul_a = 38'(mag32(v2_ff)); mul_b = mag32(v2_ff); end
         ST_MN:   begin mul_a = 38'(mu_ff); mul_b = n_ff; end
         ST_MP:   begin mul_a = 38'(mu_ff); mul_b = mag32(v0_ff); end
         ST_MU2:  begin mul_a = 38'(mu_ff); mul_b = 32'(mu_ff); end
         ST_S:    begin mul_a = p0_ff[37:0]; mul_b = 32'(mu_ff); end
         ST_T1:   begin mul_a = 38'(mag32(v1_ff)); mul_b = s_ff; end
         ST_T2:   begin mul_a = 38'(mag32(v2_ff)); mul_b = s_ff; end
         ST_D0:   begin mul_a = 38'(mag32(d0_ff)); mul_b = mag32(d0_ff); end
         ST_D1:   begin mul_a = 38'(mag32(d1_ff)); mul_b = mag32(d1_ff); end
         ST_D2:   begin mul_a = 38'(mag32(d2_ff)); mul_b = mag32(d2_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Sequencer: next state and commands to the shared unit.
   always_comb begin
      state_in   = state_ff;
      iter_cmd   = '0;
      iter_opnd  = '0;
      iter_divsr = '0;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_Q0;
         ST_Q0:    state_in = ST_Q1;
         ST_Q1:    state_in = ST_Q2;
         ST_Q2:    state_in = ST_U1;
         ST_U1:    state_in = ST_U2;
         ST_U2:    state_in = ST_SQU;
         ST_SQU: begin
            iter_cmd  = '{start: 1'b1, is_sqrt: 1'b1, steps: SQRT_STEPS};
            iter_opnd = 70'(x_ff + mul_ff[63:0]);
            state_in  = ST_WSQU;
         end
         ST_WSQU:  if (iter_done) state_in = ST_MNU;
         ST_MNU:   state_in = ST_VEC;
         ST_VEC:   state_in = ST_V1;
         ST_V1:    state_in = ST_V2;
         ST_V2:    state_in = ST_SQV;
         ST_SQV: begin
            iter_cmd  = '{start: 1'b1, is_sqrt: 1'b1, steps: SQRT_STEPS};
            iter_opnd = 70'(x_ff + mul_ff[63:0]);
            state_in  = ST_WSQV;
         end
         ST_WSQV:  if (iter_done) state_in = ST_MN;
         ST_MN:    state_in = ST_MP;
         ST_MP:    state_in = ST_MU2;
         ST_MU2:   state_in = ST_CHK;
         ST_CHK: begin
            if (zero_proj || keep_proj) begin
               state_in = ST_DIFF;
            end else begin
               // n' = a*2^16 / (mu^2 + 2^32), quotient rounded toward zero
               iter_cmd   = '{start: 1'b1, is_sqrt: 1'b0, steps: CONE_STEPS};
               iter_opnd  = 70'({a_val[52:0], 16'h0000});
               iter_divsr = 41'(mul_ff[39:0]) + (41'(1) << 32);
               state_in   = ST_WDIV;
            end
         end
         ST_WDIV:  if (iter_done) state_in = ST_S;
         ST_S:     state_in = ST_SCAP;
         ST_SCAP:  state_in = ST_T1;
         ST_T1:    state_in = ST_DT1;
         ST_DT1: begin
            iter_cmd   = '{start: 1'b1, is_sqrt: 1'b0, steps: TAN_STEPS};
            iter_opnd  = 70'(mul_ff[63:0]);
            iter_divsr = 41'(n_ff);
            state_in   = ST_WT1;
         end
         ST_WT1:   if (iter_done) state_in = ST_T2;
         ST_T2:    state_in = ST_DT2;
         ST_DT2: begin
            iter_cmd   = '{start: 1'b1, is_sqrt: 1'b0, steps: TAN_STEPS};
            iter_opnd  = 70'(mul_ff[63:0]);
            iter_divsr = 41'(n_ff);
            state_in   = ST_WT2;
         end
         ST_WT2:   if (iter_done) state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_D0;
         ST_D0:    state_in = ST_D1;
         ST_D1:    state_in = ST_D2;
         ST_D2:    state_in = ST_ACC;
         ST_ACC:   state_in = last_ff ? ST_LSQ1 : ST_IDLE;
         ST_LSQ1: begin
            iter_cmd  = '{start: 1'b1, is_sqrt: 1'b1, steps: SQRT_STEPS};
            iter_opnd = 70'(residual_sum_ff);
            state_in  = ST_WLSQ1;
         end
         ST_WLSQ1: if (iter_done) state_in = ST_LSQ2;
         ST_LSQ2: begin
            iter_cmd  = '{start: 1'b1, is_sqrt: 1'b1, steps: SQRT_STEPS};
            iter_opnd = 70'(offset_sum_ff);
            state_in  = ST_WLSQ2;
         end
         ST_WLSQ2: if (iter_done) state_in = ST_FDIV;
         ST_FDIV: begin
            // The divisor is at least 1.0, so the quotient never exceeds the root and fits.
            iter_cmd   = '{start: 1'b1, is_sqrt: 1'b0, steps: TAN_STEPS};
            iter_opnd  = 70'(e_ff) << FRAC_BITS;
            iter_divsr = 41'(n_ff) + (41'(1) << FRAC_BITS);
            state_in   = ST_WFDIV;
         end
         ST_WFDIV: if (iter_done) state_in = ST_EMIT;
         ST_EMIT:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_tvalid_ff   <= 1'b0;
         tolerance_ff    <= TOL_RESET;
         residual_sum_ff <= '0;
         offset_sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mul_ff   <= 70'(mul_a) * 70'(mul_b);
         if (csr_wr_en) begin
            tolerance_ff <= csr_wr_data;
         end
         // A new result replaces the one being taken in the same cycle.
         if (state_ff == ST_EMIT && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  r0_ff   <= req_tdata[31:0];
                  r1_ff   <= req_tdata[63:32];
                  r2_ff   <= req_tdata[95:64];
                  u0_ff   <= req_tdata[127:96];
                  u1_ff   <= req_tdata[159:128];
                  u2_ff   <= req_tdata[191:160];
                  mu_ff   <= req_tdata[211:192];
                  q0_ff   <= req_tdata[243:212];
                  q1_ff   <= req_tdata[275:244];
                  q2_ff   <= req_tdata[307:276];
                  last_ff <= req_tlast;
               end
            end
            ST_Q1:    sumq_ff <= mul_ff[63:0];
            ST_Q2:    sumq_ff <= sumq_ff + mul_ff[63:0];
            ST_U1:    sumq_ff <= sumq_ff + mul_ff[63:0];
            ST_U2:    x_ff <= mul_ff[63:0];
            ST_WSQU:  if (iter_done) nut_ff <= iter_result[31:0];
            ST_VEC: begin
               v0_ff <= sat32(40'(r0_ff) - 40'(u0_ff) - $signed({4'b0000, mnu}));
               v1_ff <= sat32(40'(r1_ff) - 40'(u1_ff));
               v2_ff <= sat32(40'(r2_ff) - 40'(u2_ff));
            end
            ST_V2:    x_ff <= mul_ff[63:0];
            ST_WSQV:  if (iter_done) n_ff <= iter_result[31:0];
            ST_MP:    mn_ff <= mul_ff[51:0];
            ST_MU2:   mup_ff <= mul_ff[51:0];
            ST_CHK: begin
               if (zero_proj) begin
                  p0_ff <= '0;
                  p1_ff <= '0;
                  p2_ff <= '0;
               end else if (keep_proj) begin
                  p0_ff <= 39'(v0_ff);
                  p1_ff <= v1_ff;
                  p2_ff <= v2_ff;
               end
            end
            ST_WDIV:  if (iter_done) p0_ff <= $signed({1'b0, iter_result});
            ST_SCAP: begin
               // mu*n' may not exceed the tangential length
               s_ff <= (s_raw > 43'(n_ff)) ? n_ff : s_raw[31:0];
            end
            ST_WT1: begin
               if (iter_done) begin
                  p1_ff <= v1_ff[31] ? $signed(32'd0 - iter_result[31:0])
                                     : $signed(iter_result[31:0]);
               end
            end
            ST_WT2: begin
               if (iter_done) begin
                  p2_ff <= v2_ff[31] ? $signed(32'd0 - iter_result[31:0])
                                     : $signed(iter_result[31:0]);
               end
            end
            ST_DIFF: begin
               d0_ff <= sat32(40'(r0_ff) - 40'(p0_ff));
               d1_ff <= sat32(40'(r1_ff) - 40'(p1_ff));
               d2_ff <= sat32(40'(r2_ff) - 40'(p2_ff));
            end
            ST_D1:    x_ff <= mul_ff[63:0];
            ST_D2:    x_ff <= acc;
            ST_ACC: begin
               residual_sum_ff <= sat_add64(residual_sum_ff, acc);
               offset_sum_ff   <= sat_add64(offset_sum_ff, sumq_ff);
            end
            ST_WLSQ1: if (iter_done) e_ff <= iter_result[31:0];
            ST_WLSQ2: if (iter_done) n_ff <= iter_result[31:0];
            ST_WFDIV: if (iter_done) err_ff <= iter_result[31:0];
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_tdata_ff    <= err_ff;
                  rsp_tuser_ff    <= (err_ff > tolerance_ff);
                  residual_sum_ff <= '0;
                  offset_sum_ff   <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // The shared unit only finishes while the sequencer is waiting for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      iter_done |-> (state_ff == ST_WSQU || state_ff == ST_WSQV || state_ff == ST_WDIV ||
                     state_ff == ST_WT1 || state_ff == ST_WT2 || state_ff == ST_WLSQ1 ||
                     state_ff == ST_WLSQ2 || state_ff == ST_WFDIV))
      else $error("iterative unit finished outside a wait state");

   // An accepted contact starts the sequence at once.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_Q0))
      else $error("accepted contact did not start the sequence");

   // Delivering a result presents it and clears both sums for the next problem.
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_free) |=>
         (rsp_tvalid_ff && residual_sum_ff == 64'd0 && offset_sum_ff == 64'd0))
      else $error("result emitted without clearing the sums");

   // The capped tangential scale never exceeds the tangential length.
   a_scale_capped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T1) |-> (s_ff <= n_ff))
      else $error("tangential scale above its cap");

endmodule

// ===== sv/fcrn_iter_unit.sv =====
// Shared bit-serial unit: restoring division or integer square root, one bit per cycle.
module fcrn_iter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fcrn_pkg::fcrn_iter_cmd_type          cmd,
   input  logic [fcrn_pkg::ITER_OPND_W-1:0]     operand,
   input  logic [fcrn_pkg::ITER_DIVSR_W-1:0]    divisor,
   output logic                                 done,
   output logic [fcrn_pkg::ITER_ROOT_W-1:0]     result
);
   import fcrn_pkg::*;

   logic                     run_ff;
   logic                     done_ff;
   logic                     sqrt_ff;
   logic [ITER_CNT_W-1:0]    cnt_ff;
   logic [ITER_REM_W-1:0]    rem_ff;
   logic [ITER_OPND_W-1:0]   src_ff;
   logic [ITER_ROOT_W-1:0]   root_ff;
   logic [ITER_DIVSR_W-1:0]  div_ff;

   logic [ITER_REM_W-1:0]    rem_sh;
   logic [ITER_REM_W-1:0]    opnd;
   logic [ITER_REM_W:0]      diff;
   logic                     ge;
   logic [6:0]               shamt;
   logic [ITER_OPND_W-1:0]   rem_init;

   // Sqrt takes two radicand bits a step and trials 4*root+1; division takes one bit.
   always_comb begin
      rem_sh   = sqrt_ff ? {rem_ff[ITER_REM_W-3:0], src_ff[ITER_OPND_W-1 -: 2]}
                         : {rem_ff[ITER_REM_W-2:0], src_ff[ITER_OPND_W-1]};
      opnd     = sqrt_ff ? {2'b00, root_ff, 2'b01} : {1'b0, div_ff};
      diff     = {1'b0, rem_sh} - {1'b0, opnd};
      ge       = !diff[ITER_REM_W];
      shamt    = 7'(ITER_OPND_W) - {1'b0, cmd.steps};
      rem_init = operand >> cmd.steps;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            run_ff  <= 1'b1;
            sqrt_ff <= cmd.is_sqrt;
            cnt_ff  <= cmd.steps;
            root_ff <= '0;
            div_ff  <= divisor;
            if (cmd.is_sqrt) begin
               rem_ff <= '0;
               src_ff <= {operand[63:0], 6'b0};
            end else begin
               rem_ff <= rem_init[ITER_REM_W-1:0];
               src_ff <= operand << shamt;
            end
         end else if (run_ff) begin
            rem_ff  <= ge ? diff[ITER_REM_W-1:0] : rem_sh;
            root_ff <= {root_ff[ITER_ROOT_W-2:0], ge};
            src_ff  <= sqrt_ff ? {src_ff[ITER_OPND_W-3:0], 2'b00}
                               : {src_ff[ITER_OPND_W-2:0], 1'b0};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == ITER_CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = root_ff;

endmodule
